/* hdl/srmf_pkg.sv */
// Package for the sorted range max frequency unit.
// Types, default sizes and the queue item layout shared by the front end, back end and top level.
package srmf_pkg;

  localparam int unsigned MaxElementsDef = 1024;
  localparam int unsigned TableLevelsDef = 11;
  localparam int unsigned IdxW = 11;
  localparam int unsigned ValW = 32;
  localparam int unsigned FreqW = 11;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APP_CHK,
    ST_APP_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RM_RD1,
    ST_RM_RD2,
    ST_RM_RD3,
    ST_RESULT
  } state_e;

  typedef struct packed {
    req_e                   req;
    logic signed [ValW-1:0] value;
    logic [IdxW-1:0]        left_index;
    logic [IdxW-1:0]        right_index;
  } item_t;

endpackage

/* hdl/srmf_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module srmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/srmf_front.sv */
// Front end: accepts items, decodes the request and queues all but REQ_NONE items (two deep).
// Depends on srmf_pkg.
module srmf_front import srmf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic [IdxW-1:0]        left_index_i,
  input  logic [IdxW-1:0]        right_index_i,
  output logic                   q_valid_o,
  output item_t                  q_item_o,
  input  logic                   q_pop_i
);

  item_t       slot_q [2];
  item_t       slot_d [2];
  logic [1:0]  fill_q, fill_d;
  logic        accept, push;
  item_t       new_item;

  assign in_stall_o = (fill_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  // REQ_NONE items are taken and dropped here
  assign push       = accept && (req_e'(req_type_i) != REQ_NONE);

  assign new_item.req         = req_e'(req_type_i);
  assign new_item.value       = value_i;
  assign new_item.left_index  = left_index_i;
  assign new_item.right_index = right_index_i;

  assign q_valid_o = (fill_q != 2'd0);
  assign q_item_o  = slot_q[0];

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    if (q_pop_i && q_valid_o) begin
      slot_d[0] = slot_q[1];
      fill_d    = fill_d - 2'd1;
    end
    if (push) begin
      slot_d[fill_d[0]] = new_item;
      fill_d            = fill_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0 && push) |=> (fill_q == 2'd1))
    else $error("push into empty queue lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == 2'd0) |-> !q_valid_o)
    else $error("empty queue shows an item");

endmodule

/* hdl/srmf_back.sv */
// Back end: run tracking, banked sparse max table, query sequencer, result register.
// Depends on srmf_pkg and srmf_ram.
module srmf_back import srmf_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef,
  parameter int unsigned TableLevels = TableLevelsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  item_t             q_item_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [FreqW-1:0]  max_frequency_o,
  output logic              bad_query_o
);

  localparam int unsigned AW  = $clog2(MaxElements);
  localparam int unsigned CW  = $clog2(MaxElements + 1);
  localparam int unsigned XW  = (CW > IdxW) ? CW : IdxW;
  localparam int unsigned LKW = $clog2(TableLevels + 1);
  localparam int unsigned LIW = $clog2(TableLevels);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     run_q, run_d;
  logic [ValW-1:0]   last_q, last_d;
  logic [CW-1:0]     prev_q, prev_d;
  logic [AW-1:0]     p_q, p_d;
  logic [LKW-1:0]    k_q, k_d;
  logic [AW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]     t_q, t_d, lead_q, lead_d, part_q, part_d;
  logic [LIW-1:0]    qk_q, qk_d;
  logic [FreqW-1:0]  res_q, res_d;
  logic              resbad_q, resbad_d;
  logic              out_valid_q;
  logic [FreqW-1:0]  out_freq_q;
  logic              out_bad_q;

  logic [TableLevels-1:0] we;
  logic [AW-1:0]          waddr, raddr;
  logic [CW-1:0]          wdata;
  logic [CW-1:0]          rd [TableLevels];

  logic [XW-1:0]     span, jx, ax, bx, cntx;
  logic [AW-1:0]     j;
  logic [LIW-1:0]    rd_lvl;
  logic [CW-1:0]     maxv, t_next, len, ans;
  int                fl;
  logic              out_free;

  for (genvar g = 0; g < TableLevels; g++) begin : g_bank
    srmf_ram #(.Width(CW), .Depth(MaxElements)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(raddr),
      .rdata_o(rd[g])
    );
  end

  function automatic logic [FreqW-1:0] sat(input logic [CW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    return (w > XW'({FreqW{1'b1}})) ? {FreqW{1'b1}} : FreqW'(v);
  endfunction

  // level k entry j = p+1-2^k; its upper half is the value just made one level down
  assign span   = XW'(1) << k_q;
  assign jx     = XW'(p_q) + XW'(1) - span;
  assign j      = AW'(jx);
  assign rd_lvl = LIW'(k_q - LKW'(1));
  assign ax     = XW'(q_item_i.left_index);
  assign bx     = XW'(q_item_i.right_index);
  assign cntx   = XW'(count_q);
  assign t_next = t_q + CW'(1);
  assign len    = CW'(hi_q) - t_q + CW'(1);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fl = 0;
    for (int i = 0; i < CW; i++) begin
      if (len[i]) fl = i;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    run_d    = run_q;
    last_d   = last_q;
    prev_d   = prev_q;
    p_d      = p_q;
    k_d      = k_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    t_d      = t_q;
    lead_d   = lead_q;
    part_d   = part_q;
    qk_d     = qk_q;
    res_d    = res_q;
    resbad_d = resbad_q;
    we       = '0;
    waddr    = j;
    wdata    = prev_q;
    raddr    = j;
    maxv     = '0;
    ans      = '0;
    q_pop_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.req)
            REQ_APPEND: begin
              if (count_q < CW'(MaxElements)) begin
                run_d   = (count_q != '0 && last_q == q_item_i.value) ?
                          run_q + CW'(1) : CW'(1);
                we[0]   = 1'b1;
                waddr   = AW'(count_q);
                wdata   = run_d;
                prev_d  = run_d;
                p_d     = AW'(count_q);
                last_d  = q_item_i.value;
                count_d = count_q + CW'(1);
                k_d     = LKW'(1);
                state_d = ST_APP_CHK;
              end
            end
            REQ_CLEAR: begin
              count_d = '0;
              run_d   = '0;
            end
            REQ_QUERY: begin
              if (ax == '0 || bx == '0 || ax > cntx || bx > cntx) begin
                res_d    = '0;
                resbad_d = 1'b1;
                state_d  = ST_RESULT;
              end else if (ax > bx) begin
                res_d    = '0;
                resbad_d = 1'b0;
                state_d  = ST_RESULT;
              end else begin
                lo_d    = AW'(ax - XW'(1));
                hi_d    = AW'(bx - XW'(1));
                t_d     = CW'(ax - XW'(1));
                state_d = ST_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_APP_CHK: begin
        if (k_q >= LKW'(TableLevels) || XW'(p_q) + XW'(1) < span) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_APP_WR;
        end
      end
      ST_APP_WR: begin
        maxv   = (rd[rd_lvl] > prev_q) ? rd[rd_lvl] : prev_q;
        we[LIW'(k_q)] = 1'b1;
        wdata  = maxv;
        prev_d = maxv;
        k_d    = k_q + LKW'(1);
        state_d = ST_APP_CHK;
      end
      ST_SCAN_RD: begin
        raddr   = AW'(t_q);
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rd[0] > CW'(1)) begin
          if (t_next > CW'(hi_q)) begin
            res_d    = sat(t_next - CW'(lo_q));
            resbad_d = 1'b0;
            state_d  = ST_RESULT;
          end else begin
            t_d     = t_next;
            state_d = ST_SCAN_RD;
          end
        end else begin
          lead_d  = t_q - CW'(lo_q);
          qk_d    = (fl > int'(TableLevels) - 1) ? LIW'(TableLevels - 1) : LIW'(fl);
          state_d = ST_RM_RD1;
        end
      end
      ST_RM_RD1: begin
        raddr   = AW'(t_q);
        state_d = ST_RM_RD2;
      end
      ST_RM_RD2: begin
        part_d  = rd[qk_q];
        raddr   = AW'(XW'(hi_q) + XW'(1) - (XW'(1) << qk_q));
        state_d = ST_RM_RD3;
      end
      ST_RM_RD3: begin
        maxv     = (rd[qk_q] > part_q) ? rd[qk_q] : part_q;
        ans      = (maxv > lead_q) ? maxv : lead_q;
        res_d    = sat(ans);
        resbad_d = 1'b0;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      run_q   <= run_d;
      if (state_q == ST_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q   <= last_d;
    prev_q   <= prev_d;
    p_q      <= p_d;
    k_q      <= k_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    t_q      <= t_d;
    lead_q   <= lead_d;
    part_q   <= part_d;
    qk_q     <= qk_d;
    res_q    <= res_d;
    resbad_q <= resbad_d;
    if (state_q == ST_RESULT && out_free) begin
      out_freq_q <= res_q;
      out_bad_q  <= resbad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign max_frequency_o = out_freq_q;
  assign bad_query_o     = out_bad_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MaxElements))
    else $error("element count beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && out_free) |=> out_valid_q)
    else $error("finished query not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT && resbad_q) |-> (res_q == '0))
    else $error("bad query with non-zero count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == ST_IDLE && q_valid_i))
    else $error("queue popped while busy");

endmodule

/* hdl/sorted_range_max_frequency_unit.sv */
// Top level: range max frequency over a sorted array, sparse max table in banked RAMs.
// Flow: an item waits in the input queue; an append writes level 0, then a check and a write
// step for each table level it fills; a query scans the leading run one entry at a time in
// the level 0 bank, then reads two table entries unless the run covers the whole range;
// bad or reversed queries go straight to the result. One item is worked on at a time.
// Reset clears count, run length and handshake state; table RAMs need no clearing pass.
module sorted_range_max_frequency_unit import srmf_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef,
  parameter int unsigned TableLevels = TableLevelsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic [IdxW-1:0]        left_index_i,
  input  logic [IdxW-1:0]        right_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FreqW-1:0]       max_frequency_o,
  output logic                   bad_query_o
);

  logic  q_valid, q_pop;
  item_t q_item;

  srmf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .left_index_i (left_index_i),
    .right_index_i(right_index_i),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  srmf_back #(.MaxElements(MaxElements), .TableLevels(TableLevels)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .max_frequency_o(max_frequency_o),
    .bad_query_o    (bad_query_o)
  );

endmodule
